/* sv/llst_pkg.sv */
// ----------------------------------------------------------------------------
// llst_pkg: shared types and constants for the least loaded server table
// Request/response payloads, table entry words, control bundles and codes.
// ----------------------------------------------------------------------------
package llst_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int LOAD_W = 25;
    localparam int AGE_W  = 16;
    localparam int KEY_W  = 1 + LOAD_W + AGE_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOM_WEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_WEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANY_TYPE      = 2'd3;

    localparam logic [7:0]  RST_ROOM_WEIGHT   = 8'd70;
    localparam logic [7:0]  RST_USER_WEIGHT   = 8'd30;
    localparam logic [15:0] RST_ACTIVE_WINDOW = 16'd35;
    localparam logic [15:0] RST_ANY_TYPE      = 16'd0;

    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_FIND   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] service_type;
        logic [31:0] server_addr;
        logic [47:0] endpoint;
        logic [15:0] room_count;
        logic [15:0] user_count;
        logic [31:0] now_seconds;
        logic [15:0] room_index;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       chosen_addr;
        logic [47:0]       chosen_endpoint;
        logic              chosen_active;
        logic [LOAD_W-1:0] chosen_load;
    } t_rsp;

    // fields fixed when an entry is added
    typedef struct packed {
        logic [15:0]      stype;
        logic [31:0]      addr;
        logic [47:0]      endpoint;
        logic [AGE_W-1:0] add_order;
    } t_ent_stat;

    // fields refreshed by every update that hits or adds an entry
    typedef struct packed {
        logic [15:0] rooms;
        logic [15:0] users;
        logic [31:0] seen;
    } t_ent_dyn;

    typedef struct packed {
        logic start;
        logic issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic last_issue;
        logic pipe_empty;
        logic out_free;
    } t_sts;

endpackage

/* sv/llst_ram.sv */
// ----------------------------------------------------------------------------
// llst_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module llst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/llst_ctrl.sv */
// ----------------------------------------------------------------------------
// llst_ctrl: request sequencer
// Accepts a request, runs one scan over the table, then commits the result.
// ----------------------------------------------------------------------------
module llst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  llst_pkg::t_sts   i_sts,
    output llst_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty && i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_finish_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> $past(r_state == S_DRAIN || r_state == S_SCAN))
        else $error("finish outside of drain");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.last_issue) |=> (r_state == S_DRAIN))
        else $error("scan did not end after last entry");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> !o_cmd.issue && !o_cmd.finish)
        else $error("start overlaps scan or finish");

endmodule

/* sv/llst_dpath.sv */
// ----------------------------------------------------------------------------
// llst_dpath: table storage, scan pipeline and result register
// Read, evaluate and rank stages over the entries; commit on finish.
// ----------------------------------------------------------------------------
module llst_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  llst_pkg::t_cmd                       i_cmd,
    output llst_pkg::t_sts                       o_sts,
    input  llst_pkg::t_req                       i_req,
    input  logic                                 i_cfg_we,
    input  logic [llst_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [llst_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output llst_pkg::t_rsp                       o_out_rsp
);

    localparam int N     = llst_pkg::TABLE_ENTRIES;
    localparam int IW    = llst_pkg::IDX_W;
    localparam int LW    = llst_pkg::LOAD_W;
    localparam int AW    = llst_pkg::AGE_W;
    localparam int KW    = llst_pkg::KEY_W;
    localparam int STATW = $bits(llst_pkg::t_ent_stat);
    localparam int DYNW  = $bits(llst_pkg::t_ent_dyn);

    // configuration
    logic [7:0]  r_rw;
    logic [7:0]  r_uw;
    logic [15:0] r_aw;
    logic [15:0] r_any;

    // table control
    logic [N-1:0]  r_valid;
    logic [AW-1:0] r_add_cnt;

    llst_pkg::t_req r_req;

    // scan pipeline
    logic [IW-1:0] r_rd_idx;
    logic          r_a_vld;
    logic [IW-1:0] r_a_idx;
    logic          r_b_vld;
    logic [IW-1:0] r_b_idx;
    logic          r_b_ev;
    logic          r_b_mt_s;
    logic          r_b_mt_any;
    logic          r_b_mt_addr;
    logic [23:0]   r_b_prm;
    logic [23:0]   r_b_pus;
    logic          r_b_inact;
    logic [AW-1:0] r_b_age;
    logic [31:0]   r_b_addr;
    logic [47:0]   r_b_ep;

    // trackers
    logic          r_s_have;
    logic [KW-1:0] r_s_key;
    logic [31:0]   r_s_addr;
    logic [47:0]   r_s_ep;
    logic          r_any_have;
    logic [KW-1:0] r_any_key;
    logic [31:0]   r_any_addr;
    logic [47:0]   r_any_ep;
    logic          r_hit_have;
    logic [IW-1:0] r_hit_idx;
    logic          r_free_have;
    logic [IW-1:0] r_free_idx;
    logic          r_del_any;

    logic           r_out_valid;
    llst_pkg::t_rsp r_out_rsp;

    llst_pkg::t_ent_stat rd_stat;
    llst_pkg::t_ent_dyn  rd_dyn;
    llst_pkg::t_ent_stat wr_stat;
    llst_pkg::t_ent_dyn  wr_dyn;
    logic [STATW-1:0]    rd_stat_w;
    logic [DYNW-1:0]     rd_dyn_w;

    logic          do_refresh;
    logic          do_add;
    logic [IW-1:0] dyn_waddr;
    llst_pkg::t_rsp n_rsp;

    logic [31:0]   a_diff;
    logic [LW-1:0] c_load;
    logic [KW-1:0] c_key;
    logic          c_s_take;
    logic          c_any_take;
    logic          c_hit;
    logic          c_free;
    logic          c_del;
    logic          is_find;

    assign rd_stat = llst_pkg::t_ent_stat'(rd_stat_w);
    assign rd_dyn  = llst_pkg::t_ent_dyn'(rd_dyn_w);

    // ------------------------------------------------------------------ storage
    assign wr_stat.stype     = r_req.service_type;
    assign wr_stat.addr      = r_req.server_addr;
    assign wr_stat.endpoint  = r_req.endpoint;
    assign wr_stat.add_order = r_add_cnt;
    assign wr_dyn.rooms      = r_req.room_count;
    assign wr_dyn.users      = r_req.user_count;
    assign wr_dyn.seen       = r_req.now_seconds;

    assign dyn_waddr = r_hit_have ? r_hit_idx : r_free_idx;

    llst_ram #(.WIDTH(STATW), .DEPTH(N)) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (do_add),
        .i_waddr (r_free_idx),
        .i_wdata (wr_stat),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_stat_w)
    );

    llst_ram #(.WIDTH(DYNW), .DEPTH(N)) u_dyn_ram (
        .i_clk   (i_clk),
        .i_we    (do_refresh || do_add),
        .i_waddr (dyn_waddr),
        .i_wdata (wr_dyn),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_dyn_w)
    );

    // ------------------------------------------------------------------ status
    assign o_sts.last_issue = (r_rd_idx == IW'(N - 1));
    assign o_sts.pipe_empty = !r_a_vld && !r_b_vld;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------ rank stage
    assign a_diff     = r_req.now_seconds - rd_dyn.seen;
    assign c_load     = LW'(r_b_prm) + LW'(r_b_pus);
    assign c_key      = {r_b_inact, c_load, r_b_age};
    assign c_s_take   = r_b_vld && r_b_ev && r_b_mt_s && (!r_s_have || c_key < r_s_key);
    assign c_any_take = r_b_vld && r_b_ev && r_b_mt_any
                        && (!r_any_have || c_key < r_any_key);
    assign c_hit      = r_b_vld && r_b_ev && r_b_mt_s && r_b_mt_addr && !r_hit_have;
    assign c_free     = r_b_vld && !r_b_ev && !r_free_have;
    assign c_del      = r_b_vld && r_b_ev && r_b_mt_addr && (r_req.mode == llst_pkg::MODE_DELETE);

    // ------------------------------------------------------------------ commit
    assign is_find    = (r_req.mode == llst_pkg::MODE_FIND) && (r_req.room_index == '0);
    assign do_refresh = i_cmd.finish && (r_req.mode == llst_pkg::MODE_UPDATE) && r_hit_have;
    assign do_add     = i_cmd.finish && (r_req.mode == llst_pkg::MODE_UPDATE) && !r_hit_have
                        && r_free_have;

    always_comb begin
        n_rsp        = '0;
        n_rsp.status = llst_pkg::ST_NOT_FOUND;
        case (r_req.mode)
            llst_pkg::MODE_UPDATE: begin
                n_rsp.status = (r_hit_have || r_free_have) ? llst_pkg::ST_OK : llst_pkg::ST_FULL;
            end
            llst_pkg::MODE_DELETE: begin
                n_rsp.status = r_del_any ? llst_pkg::ST_OK : llst_pkg::ST_NOT_FOUND;
            end
            default: begin
                if (is_find && r_s_have) begin
                    n_rsp.status          = llst_pkg::ST_OK;
                    n_rsp.chosen_addr     = r_s_addr;
                    n_rsp.chosen_endpoint = r_s_ep;
                    n_rsp.chosen_active   = !r_s_key[KW-1];
                    n_rsp.chosen_load     = r_s_key[AW +: LW];
                end else if (is_find && r_any_have) begin
                    n_rsp.status          = llst_pkg::ST_OK;
                    n_rsp.chosen_addr     = r_any_addr;
                    n_rsp.chosen_endpoint = r_any_ep;
                    n_rsp.chosen_active   = !r_any_key[KW-1];
                    n_rsp.chosen_load     = r_any_key[AW +: LW];
                end
            end
        endcase
    end

    // ------------------------------------------------------------------ control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rw        <= llst_pkg::RST_ROOM_WEIGHT;
            r_uw        <= llst_pkg::RST_USER_WEIGHT;
            r_aw        <= llst_pkg::RST_ACTIVE_WINDOW;
            r_any       <= llst_pkg::RST_ANY_TYPE;
            r_valid     <= '0;
            r_add_cnt   <= '0;
            r_rd_idx    <= '0;
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_s_have    <= 1'b0;
            r_any_have  <= 1'b0;
            r_hit_have  <= 1'b0;
            r_free_have <= 1'b0;
            r_del_any   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    llst_pkg::CFG_ROOM_WEIGHT:   r_rw  <= i_cfg_data[7:0];
                    llst_pkg::CFG_USER_WEIGHT:   r_uw  <= i_cfg_data[7:0];
                    llst_pkg::CFG_ACTIVE_WINDOW: r_aw  <= i_cfg_data;
                    llst_pkg::CFG_ANY_TYPE:      r_any <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.issue && !o_sts.last_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            r_a_vld <= i_cmd.issue;
            r_b_vld <= r_a_vld;

            if (i_cmd.start) begin
                r_s_have    <= 1'b0;
                r_any_have  <= 1'b0;
                r_hit_have  <= 1'b0;
                r_free_have <= 1'b0;
                r_del_any   <= 1'b0;
            end else begin
                if (c_s_take)   r_s_have    <= 1'b1;
                if (c_any_take) r_any_have  <= 1'b1;
                if (c_hit)      r_hit_have  <= 1'b1;
                if (c_free)     r_free_have <= 1'b1;
                if (c_del)      r_del_any   <= 1'b1;
            end

            if (c_del) begin
                r_valid[r_b_idx] <= 1'b0;
            end
            if (do_add) begin
                r_valid[r_free_idx] <= 1'b1;
                r_add_cnt           <= r_add_cnt + 1'b1;
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------ payload regs
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= i_req;
        end

        r_a_idx <= r_rd_idx;

        if (r_a_vld) begin
            r_b_idx     <= r_a_idx;
            r_b_ev      <= r_valid[r_a_idx];
            r_b_mt_s    <= (rd_stat.stype == r_req.service_type);
            r_b_mt_any  <= (rd_stat.stype == r_any);
            r_b_mt_addr <= (rd_stat.addr == r_req.server_addr);
            r_b_prm     <= 24'(r_rw) * 24'(rd_dyn.rooms);
            r_b_pus     <= 24'(r_uw) * 24'(rd_dyn.users);
            r_b_inact   <= !(a_diff < 32'(r_aw));
            r_b_age     <= r_add_cnt - rd_stat.add_order;
            r_b_addr    <= rd_stat.addr;
            r_b_ep      <= rd_stat.endpoint;
        end

        if (c_s_take) begin
            r_s_key  <= c_key;
            r_s_addr <= r_b_addr;
            r_s_ep   <= r_b_ep;
        end
        if (c_any_take) begin
            r_any_key  <= c_key;
            r_any_addr <= r_b_addr;
            r_any_ep   <= r_b_ep;
        end
        if (c_hit) begin
            r_hit_idx <= r_b_idx;
        end
        if (c_free) begin
            r_free_idx <= r_b_idx;
        end

        if (i_cmd.finish) begin
            r_out_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites a pending response");

    a_cnt_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_add_cnt != $past(r_add_cnt)) |-> $past(do_add))
        else $error("add counter moved without an add");

    a_valid_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_valid & ~$past(r_valid)) != '0) |-> $past(do_add))
        else $error("entry became valid without an add");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_b_vld) |-> $past(r_a_vld))
        else $error("rank stage active without a read");

endmodule

/* sv/least_loaded_server_table.sv */
// ----------------------------------------------------------------------------
// least_loaded_server_table: server table with least loaded lookup
// Update/add, delete by address and least loaded find over a slot table.
// ----------------------------------------------------------------------------
//  port group   direction  handshake                   payload
//  request      in         i_in_valid / o_in_ready     i_in_req  (t_req)
//  response     out        o_out_valid / i_out_ready   o_out_rsp (t_rsp)
//  config       in         i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
//  Every request makes one pass over the table RAMs through the read port
//  (one entry per cycle) between its accept and the next accept.
//  The response register is loaded at the end of the pass; a new request is
//  taken while it waits. A stalled response holds the next commit until taken.
//  Reset is synchronous, active low; it clears slot valid bits and control registers.
// ----------------------------------------------------------------------------
module least_loaded_server_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  llst_pkg::t_req                      i_in_req,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output llst_pkg::t_rsp                      o_out_rsp,
    input  logic                                i_cfg_we,
    input  logic [llst_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [llst_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    llst_pkg::t_cmd cmd;
    llst_pkg::t_sts sts;

    llst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    llst_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

/* verif/least_loaded_server_table_tb.sv */
// ----------------------------------------------------------------------------
// least_loaded_server_table_tb: self-checking bench for the server table
// Drives update, delete and find requests on the request channel, predicts
// each response from a local copy of the table and its registers or from a
// directed row, and checks it field by field. A short directed list comes
// first, then random phases under several register settings, with random
// idling on both channels, a long response stall and a no-idle stretch.
// ----------------------------------------------------------------------------
module least_loaded_server_table_tb;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         LIMIT_CYCLES   = 200000;
    localparam int         RX_HOLD_CYCLES = 400;

    typedef struct {
        llst_pkg::t_req req;
        bit             typed;
        logic [1:0]     status;
    } t_dir_row;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    llst_pkg::t_req                  i_in_req    = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    llst_pkg::t_rsp                  o_out_rsp;
    logic                            i_cfg_we    = 1'b0;
    logic [llst_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [llst_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // local copy of the table
    logic                       tbl_valid [llst_pkg::TABLE_ENTRIES];
    logic [15:0]                tbl_type  [llst_pkg::TABLE_ENTRIES];
    logic [31:0]                tbl_addr  [llst_pkg::TABLE_ENTRIES];
    logic [47:0]                tbl_ep    [llst_pkg::TABLE_ENTRIES];
    logic [15:0]                tbl_rooms [llst_pkg::TABLE_ENTRIES];
    logic [15:0]                tbl_users [llst_pkg::TABLE_ENTRIES];
    logic [31:0]                tbl_seen  [llst_pkg::TABLE_ENTRIES];
    logic [llst_pkg::AGE_W-1:0] tbl_order [llst_pkg::TABLE_ENTRIES];
    logic [llst_pkg::AGE_W-1:0] stamp_ctr;
    logic [7:0]                 cfg_room_w;
    logic [7:0]                 cfg_user_w;
    logic [15:0]                cfg_window;
    logic [15:0]                cfg_any_type;

    llst_pkg::t_rsp table_rsp_due [$];
    t_dir_row       dir_rows [$];
    llst_pkg::t_rsp typed_rsp = '0;
    bit             typed_ok  = 1'b0;
    bit             tx_idle_on = 1'b1;
    bit             rx_idle_on = 1'b1;
    bit             rx_stall_go = 1'b0;
    int             stall_left = 0;
    logic [15:0]    type_pool [4];
    logic [31:0]    addr_pool [6];
    logic [31:0]    clock_s = '0;
    int             n_sent = 0;
    int             n_checked = 0;
    int             n_find_hits = 0;
    int             n_full = 0;
    int             n_errors = 0;
    int             cycle_cnt = 0;

    least_loaded_server_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit type_in_table(input logic [15:0] t);
        for (int k = 0; k < llst_pkg::TABLE_ENTRIES; k++) begin
            if (tbl_valid[k] && tbl_type[k] == t) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic llst_pkg::t_rsp predict_table_op(input llst_pkg::t_req r);
        llst_pkg::t_rsp              rsp;
        int                          hit;
        int                          free_slot;
        int                          best;
        logic [15:0]                 want;
        bit                          have;
        logic [31:0]                 since;
        logic                        inact;
        logic                        b_inact;
        logic [llst_pkg::LOAD_W-1:0] load;
        logic [llst_pkg::LOAD_W-1:0] b_load;
        logic [llst_pkg::AGE_W-1:0]  age;
        logic [llst_pkg::AGE_W-1:0]  b_age;
        rsp = '0;
        rsp.status = llst_pkg::ST_NOT_FOUND;
        hit = -1;
        free_slot = -1;
        best = -1;
        b_inact = 1'b0;
        b_load = '0;
        b_age = '0;
        case (r.mode)
            llst_pkg::MODE_UPDATE: begin
                for (int k = 0; k < llst_pkg::TABLE_ENTRIES; k++) begin
                    if (tbl_valid[k]) begin
                        if (hit < 0 && tbl_type[k] == r.service_type &&
                            tbl_addr[k] == r.server_addr) begin
                            hit = k;
                        end
                    end else if (free_slot < 0) begin
                        free_slot = k;
                    end
                end
                if (hit >= 0) begin
                    tbl_rooms[hit] = r.room_count;
                    tbl_users[hit] = r.user_count;
                    tbl_seen[hit]  = r.now_seconds;
                    rsp.status = llst_pkg::ST_OK;
                end else if (free_slot >= 0) begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_type[free_slot]  = r.service_type;
                    tbl_addr[free_slot]  = r.server_addr;
                    tbl_ep[free_slot]    = r.endpoint;
                    tbl_rooms[free_slot] = r.room_count;
                    tbl_users[free_slot] = r.user_count;
                    tbl_seen[free_slot]  = r.now_seconds;
                    tbl_order[free_slot] = stamp_ctr;
                    stamp_ctr = stamp_ctr + 1'b1;
                    rsp.status = llst_pkg::ST_OK;
                end else begin
                    rsp.status = llst_pkg::ST_FULL;
                end
            end
            llst_pkg::MODE_DELETE: begin
                for (int k = 0; k < llst_pkg::TABLE_ENTRIES; k++) begin
                    if (tbl_valid[k] && tbl_addr[k] == r.server_addr) begin
                        tbl_valid[k] = 1'b0;
                        rsp.status = llst_pkg::ST_OK;
                    end
                end
            end
            llst_pkg::MODE_FIND: begin
                if (r.room_index == '0) begin
                    want = r.service_type;
                    have = 1'b1;
                    if (!type_in_table(want)) begin
                        want = cfg_any_type;
                        have = type_in_table(want);
                    end
                    if (have) begin
                        for (int k = 0; k < llst_pkg::TABLE_ENTRIES; k++) begin
                            if (tbl_valid[k] && tbl_type[k] == want) begin
                                since = r.now_seconds - tbl_seen[k];
                                inact = (since < {16'd0, cfg_window}) ? 1'b0 : 1'b1;
                                load  = cfg_room_w * tbl_rooms[k] + cfg_user_w * tbl_users[k];
                                age   = stamp_ctr - tbl_order[k];
                                if (best < 0 || inact < b_inact ||
                                    (inact == b_inact && (load < b_load ||
                                     (load == b_load && age < b_age)))) begin
                                    best = k;
                                    b_inact = inact;
                                    b_load = load;
                                    b_age = age;
                                end
                            end
                        end
                        if (best >= 0) begin
                            rsp.status          = llst_pkg::ST_OK;
                            rsp.chosen_addr     = tbl_addr[best];
                            rsp.chosen_endpoint = tbl_ep[best];
                            rsp.chosen_active   = ~b_inact;
                            rsp.chosen_load     = b_load;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    function automatic llst_pkg::t_req mk_req(input logic [1:0] mode,
                                              input logic [15:0] stype,
                                              input logic [31:0] addr, input logic [47:0] ep,
                                              input logic [15:0] rooms,
                                              input logic [15:0] users,
                                              input logic [31:0] now,
                                              input logic [15:0] ridx);
        llst_pkg::t_req r;
        r.mode         = mode;
        r.service_type = stype;
        r.server_addr  = addr;
        r.endpoint     = ep;
        r.room_count   = rooms;
        r.user_count   = users;
        r.now_seconds  = now;
        r.room_index   = ridx;
        return r;
    endfunction

    function automatic llst_pkg::t_rsp rsp_with_status(input logic [1:0] st);
        llst_pkg::t_rsp rsp;
        rsp = '0;
        rsp.status = st;
        return rsp;
    endfunction

    task automatic add_row(input llst_pkg::t_req r, input bit typed, input logic [1:0] st);
        t_dir_row row;
        row.req = r;
        row.typed = typed;
        row.status = st;
        dir_rows = {dir_rows, row};
    endtask

    function automatic llst_pkg::t_req next_random_request();
        llst_pkg::t_req r;
        int             sel;
        sel = $urandom_range(99);
        if (sel < 45) begin
            r.mode = llst_pkg::MODE_UPDATE;
        end else if (sel < 60) begin
            r.mode = llst_pkg::MODE_DELETE;
        end else if (sel < 95) begin
            r.mode = llst_pkg::MODE_FIND;
        end else begin
            r.mode = MODE_UNUSED;
        end
        r.service_type = ($urandom_range(9) == 0) ? 16'($urandom())
                                                   : type_pool[$urandom_range(3)];
        r.server_addr  = ($urandom_range(9) == 0) ? $urandom() : addr_pool[$urandom_range(5)];
        r.endpoint     = {16'($urandom()), $urandom()};
        r.room_count   = ($urandom_range(9) < 7) ? 16'($urandom_range(15)) : 16'($urandom());
        r.user_count   = ($urandom_range(9) < 7) ? 16'($urandom_range(15)) : 16'($urandom());
        if ($urandom_range(19) == 0) begin
            clock_s = clock_s + $urandom_range(70000);
        end else begin
            clock_s = clock_s + $urandom_range(8);
        end
        r.now_seconds  = clock_s;
        r.room_index   = (r.mode == llst_pkg::MODE_FIND && $urandom_range(9) != 0)
                         ? 16'd0 : 16'($urandom());
        return r;
    endfunction

    task automatic offer_request(input llst_pkg::t_req r, input bit has_typed,
                                 input llst_pkg::t_rsp typed);
        while (tx_idle_on && $urandom_range(99) < 37) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        typed_ok  = has_typed;
        typed_rsp = typed;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        n_sent++;
    endtask

    task automatic wait_for_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (table_rsp_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [llst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            llst_pkg::CFG_ROOM_WEIGHT:   cfg_room_w   = data[7:0];
            llst_pkg::CFG_USER_WEIGHT:   cfg_user_w   = data[7:0];
            llst_pkg::CFG_ACTIVE_WINDOW: cfg_window   = data;
            llst_pkg::CFG_ANY_TYPE:      cfg_any_type = data;
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] rw, input logic [7:0] uw,
                             input logic [15:0] win, input logic [15:0] any,
                             input logic [31:0] t0, input int n_items,
                             input bit idle_on, input bit pressure);
        wait_for_idle();
        cfg_write(llst_pkg::CFG_ROOM_WEIGHT, {8'd0, rw});
        cfg_write(llst_pkg::CFG_USER_WEIGHT, {8'd0, uw});
        cfg_write(llst_pkg::CFG_ACTIVE_WINDOW, win);
        cfg_write(llst_pkg::CFG_ANY_TYPE, any);
        type_pool[0] = any;
        type_pool[1] = 16'h0005;
        type_pool[2] = 16'($urandom());
        type_pool[3] = 16'($urandom());
        foreach (addr_pool[j]) addr_pool[j] = $urandom();
        clock_s = t0;
        tx_idle_on = idle_on;
        rx_idle_on = idle_on;
        if (pressure) begin
            rx_stall_go = 1'b1;
        end
        repeat (n_items) offer_request(next_random_request(), 1'b0, '0);
    endtask

    // response side: random idling, or one long hold-off on request
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (rx_stall_go) begin
            rx_stall_go = 1'b0;
            stall_left = RX_HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(rx_idle_on && $urandom_range(99) < 37);
        end
    end

    always @(posedge i_clk) begin
        llst_pkg::t_rsp want;
        llst_pkg::t_rsp got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = predict_table_op(i_in_req);
                if (i_in_req.mode == llst_pkg::MODE_FIND &&
                    want.status == llst_pkg::ST_OK) begin
                    n_find_hits++;
                end
                if (want.status == llst_pkg::ST_FULL) begin
                    n_full++;
                end
                if (typed_ok) begin
                    want = typed_rsp;
                end
                table_rsp_due = {table_rsp_due, want};
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out_rsp;
                if (table_rsp_due.size() == 0) begin
                    $error("response with no request pending");
                    n_errors++;
                end else begin
                    want = table_rsp_due.pop_front();
                    n_checked++;
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        n_errors++;
                    end
                    if (got.chosen_addr !== want.chosen_addr) begin
                        $error("chosen_addr: expected %h, got %h",
                               want.chosen_addr, got.chosen_addr);
                        n_errors++;
                    end
                    if (got.chosen_endpoint !== want.chosen_endpoint) begin
                        $error("chosen_endpoint: expected %h, got %h",
                               want.chosen_endpoint, got.chosen_endpoint);
                        n_errors++;
                    end
                    if (got.chosen_active !== want.chosen_active) begin
                        $error("chosen_active: expected %0d, got %0d",
                               want.chosen_active, got.chosen_active);
                        n_errors++;
                    end
                    if (got.chosen_load !== want.chosen_load) begin
                        $error("chosen_load: expected %0d, got %0d",
                               want.chosen_load, got.chosen_load);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_cnt, table_rsp_due.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        for (int k = 0; k < llst_pkg::TABLE_ENTRIES; k++) begin
            tbl_valid[k] = 1'b0;
        end
        stamp_ctr    = '0;
        cfg_room_w   = llst_pkg::RST_ROOM_WEIGHT;
        cfg_user_w   = llst_pkg::RST_USER_WEIGHT;
        cfg_window   = llst_pkg::RST_ACTIVE_WINDOW;
        cfg_any_type = llst_pkg::RST_ANY_TYPE;

        // empty table, unused mode
        add_row(mk_req(llst_pkg::MODE_FIND, 16'h0005, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'h0, 16'h0), 1'b1, llst_pkg::ST_NOT_FOUND);
        add_row(mk_req(llst_pkg::MODE_DELETE, 16'h0005, 32'h1234, 48'h0, 16'h0, 16'h0,
                       32'h0, 16'h0), 1'b1, llst_pkg::ST_NOT_FOUND);
        add_row(mk_req(MODE_UNUSED, 16'h0005, 32'h0, 48'h0, 16'h0, 16'h0, 32'h0, 16'h0),
                1'b1, llst_pkg::ST_NOT_FOUND);
        // field extremes
        add_row(mk_req(llst_pkg::MODE_UPDATE, 16'h0005, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                       16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'h0), 1'b1, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_UPDATE, 16'h0005, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'hFFFF_FFF0, 16'h0), 1'b1, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_FIND, 16'h0005, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'h0, 16'h0), 1'b0, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_FIND, 16'h0005, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'h0, 16'hFFFF), 1'b1, llst_pkg::ST_NOT_FOUND);
        // refresh keeps the stored endpoint
        add_row(mk_req(llst_pkg::MODE_UPDATE, 16'h0005, 32'h0, 48'h1234_5678_9ABC, 16'h1,
                       16'h0, 32'd100, 16'h0), 1'b1, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_FIND, 16'h0005, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'd200, 16'h0), 1'b0, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_FIND, 16'hFFFF, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'd200, 16'h0), 1'b1, llst_pkg::ST_NOT_FOUND);
        // fallback to any_type
        add_row(mk_req(llst_pkg::MODE_UPDATE, llst_pkg::RST_ANY_TYPE, 32'h7,
                       48'hA5A5_5A5A_A5A5, 16'h2, 16'h3, 32'd1000, 16'h0),
                1'b1, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_FIND, 16'hFFFF, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'd1010, 16'h0), 1'b0, llst_pkg::ST_OK);
        // equal load, latest add wins
        add_row(mk_req(llst_pkg::MODE_UPDATE, 16'h0005, 32'h55, 48'h5555_0000_5555, 16'h1,
                       16'h0, 32'd300, 16'h0), 1'b1, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_UPDATE, 16'h0005, 32'h0, 48'h0, 16'h1, 16'h0,
                       32'd300, 16'h0), 1'b1, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_FIND, 16'h0005, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'd301, 16'h0), 1'b0, llst_pkg::ST_OK);
        // delete hits every type with the address
        add_row(mk_req(llst_pkg::MODE_UPDATE, 16'h0006, 32'h0, 48'h6, 16'h5, 16'h5,
                       32'd300, 16'h0), 1'b1, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_DELETE, 16'h0, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'd300, 16'h0), 1'b1, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_FIND, 16'h0006, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'd301, 16'h0), 1'b0, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_DELETE, 16'h0, 32'h55, 48'h0, 16'h0, 16'h0,
                       32'd301, 16'h0), 1'b1, llst_pkg::ST_OK);
        add_row(mk_req(llst_pkg::MODE_DELETE, 16'h0, 32'h55, 48'h0, 16'h0, 16'h0,
                       32'd301, 16'h0), 1'b1, llst_pkg::ST_NOT_FOUND);
        add_row(mk_req(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
                       16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF), 1'b1, llst_pkg::ST_NOT_FOUND);
        add_row(mk_req(llst_pkg::MODE_FIND, 16'h0005, 32'h0, 48'h0, 16'h0, 16'h0,
                       32'd301, 16'h1), 1'b1, llst_pkg::ST_NOT_FOUND);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            offer_request(dir_rows[i].req, dir_rows[i].typed,
                          rsp_with_status(dir_rows[i].status));
        end

        run_phase(8'd70, 8'd30, 16'd35, 16'h0003, 32'd5000, 100, 1'b1, 1'b0);
        run_phase(8'd0, 8'd0, 16'd1, 16'h0000, 32'd0, 80, 1'b0, 1'b0);
        run_phase(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 32'hFFFF_FF80, 90, 1'b0, 1'b1);
        run_phase(8'd255, 8'd0, 16'd0, 16'h0000, 32'h8000_0000, 80, 1'b1, 1'b0);
        run_phase(8'd0, 8'd255, 16'($urandom_range(1, 65535)), 16'($urandom()),
                  $urandom(), 100, 1'b1, 1'b0);
        run_phase(8'($urandom()), 8'($urandom()), 16'($urandom_range(1, 65535)),
                  16'h0005, $urandom(), 80, 1'b1, 1'b0);

        wait_for_idle();
        repeat (llst_pkg::TABLE_ENTRIES + 8) @(posedge i_clk);
        $display("%0d requests sent, %0d responses checked in %0d cycles",
                 n_sent, n_checked, cycle_cnt);
        $display("%0d finds served a server, %0d adds hit a full table", n_find_hits, n_full);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
sv/llst_pkg.sv
sv/llst_ram.sv
sv/llst_ctrl.sv
sv/llst_dpath.sv
sv/least_loaded_server_table.sv
verif/least_loaded_server_table_tb.sv
